/* hw/rtl/mbn_pkg.sv */
package mbn_pkg;

    // Coordinate format: signed fixed point, FRAC_BITS of the bits are fraction.
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Derived widths.
    localparam int EXT_WIDTH  = COORD_WIDTH + 1;
    localparam int DIV_WIDTH  = COORD_WIDTH + FRAC_BITS;
    localparam int PROD_WIDTH = 2 * COORD_WIDTH;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Operation codes of an input beat.
    localparam logic [1:0] OP_RESTART   = 2'd0;
    localparam logic [1:0] OP_INCLUDE   = 2'd1;
    localparam logic [1:0] OP_TRANSFORM = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic        [COORD_WIDTH-1:0] t_scale;

    localparam longint BOUND_RAW   = longint'(1000) <<< FRAC_BITS;
    localparam longint COORD_MAX_L = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint BOUND_K     = (BOUND_RAW > COORD_MAX_L) ? COORD_MAX_L : BOUND_RAW;

    // The bounds start inverted so that the first included vertex replaces them.
    localparam t_coord BOUND_MIN_INIT  = t_coord'(BOUND_K);
    localparam t_coord BOUND_MAX_INIT  = t_coord'(-BOUND_K);
    localparam t_scale SCALE_LEN_RESET = t_scale'(longint'(1) <<< FRAC_BITS);

    typedef struct packed {
        logic [1:0]                  op;
        logic [2:0][COORD_WIDTH-1:0] pos;
    } t_cmd;

    typedef struct packed {
        logic   start;
        t_scale length;
        t_scale divisor;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_scale quotient;
    } t_div_rsp;

endpackage

/* hw/rtl/mbn_stream_if.sv */
interface mbn_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             operation;
    logic signed [mbn_pkg::COORD_WIDTH-1:0] pos_x;
    logic signed [mbn_pkg::COORD_WIDTH-1:0] pos_y;
    logic signed [mbn_pkg::COORD_WIDTH-1:0] pos_z;

    modport source (output valid, output operation, output pos_x, output pos_y,
                    output pos_z, input ready);
    modport sink (input valid, input operation, input pos_x, input pos_y,
                  input pos_z, output ready);
endinterface

interface mbn_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [mbn_pkg::COORD_WIDTH-1:0] norm_x;
    logic signed [mbn_pkg::COORD_WIDTH-1:0] norm_y;
    logic signed [mbn_pkg::COORD_WIDTH-1:0] norm_z;
    logic        [mbn_pkg::COORD_WIDTH-1:0] scale_out;
    logic signed [mbn_pkg::COORD_WIDTH-1:0] offset_x;
    logic signed [mbn_pkg::COORD_WIDTH-1:0] offset_y;
    logic signed [mbn_pkg::COORD_WIDTH-1:0] offset_z;

    modport source (output valid, output norm_x, output norm_y, output norm_z,
                    output scale_out, output offset_x, output offset_y,
                    output offset_z, input ready);
    modport sink (input valid, input norm_x, input norm_y, input norm_z,
                  input scale_out, input offset_x, input offset_y,
                  input offset_z, output ready);
endinterface

/* hw/rtl/mbn_front.sv */
module mbn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbn_in_if.sink        i_in,
    output logic          o_cmd_valid,
    output mbn_pkg::t_cmd o_cmd,
    input  logic          i_cmd_ready
);

    logic          r_valid;
    mbn_pkg::t_cmd r_cmd;
    logic          accept;

    assign i_in.ready  = !r_valid || i_cmd_ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Beats with the unused operation code are swallowed here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= (i_in.operation != mbn_pkg::OP_UNUSED);
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op  <= i_in.operation;
            r_cmd.pos <= {i_in.pos_z, i_in.pos_y, i_in.pos_x};
        end
    end

endmodule

/* hw/rtl/mbn_cmd_queue.sv */
module mbn_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  mbn_pkg::t_cmd i_push_data,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output mbn_pkg::t_cmd o_pop_data,
    input  logic          i_pop
);

    mbn_pkg::t_cmd                  r_mem [mbn_pkg::QUEUE_DEPTH];
    logic [mbn_pkg::QUEUE_AW-1:0]   r_wptr;
    logic [mbn_pkg::QUEUE_AW-1:0]   r_rptr;
    logic [mbn_pkg::QUEUE_AW:0]     r_count;
    logic                           push;
    logic                           pop;

    assign o_push_ready = (r_count != (mbn_pkg::QUEUE_AW + 1)'(mbn_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

/* hw/rtl/mbn_scale_div.sv */
module mbn_scale_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbn_pkg::t_div_req i_req,
    output mbn_pkg::t_div_rsp o_rsp
);

    localparam int CW   = mbn_pkg::COORD_WIDTH;
    localparam int DW   = mbn_pkg::DIV_WIDTH;
    localparam int CNTW = $clog2(DW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [CW-1:0]   r_rem;
    logic [CW-1:0]   r_div;
    logic [DW-1:0]   r_quo;
    logic [CW:0]     shifted;
    logic [CW:0]     diff;
    logic            ge;

    // Restoring division of length * 2^FRAC_BITS, one quotient bit a cycle.
    assign shifted = {r_rem, r_quo[DW-1]};
    assign ge      = (shifted >= {1'b0, r_div});
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_quo <= {i_req.length, {mbn_pkg::FRAC_BITS{1'b0}}};
        end else if (r_busy) begin
            r_rem <= ge ? diff[CW-1:0] : shifted[CW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    // A quotient that needs more than CW bits saturates.
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = (|r_quo[DW-1:CW]) ? '1 : r_quo[CW-1:0];

endmodule

/* hw/rtl/mbn_back.sv */
module mbn_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mbn_pkg::COORD_WIDTH-1:0] i_cfg_wdata,
    input  logic                            i_cmd_valid,
    input  mbn_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_pop,
    output mbn_pkg::t_div_req               o_div_req,
    input  mbn_pkg::t_div_rsp               i_div_rsp,
    mbn_out_if.source                       o_out
);

    localparam int CW = mbn_pkg::COORD_WIDTH;
    localparam int EW = mbn_pkg::EXT_WIDTH;
    localparam int PW = mbn_pkg::PROD_WIDTH;
    localparam int FB = mbn_pkg::FRAC_BITS;
    localparam int RW = PW - FB;

    localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW - 1){1'b0}}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXT  = 4'd1;
    localparam logic [3:0] S_EMAX = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_OFF  = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_MAG  = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]             r_state;
    logic [3:0]             n_state;
    mbn_pkg::t_coord        r_max [3];
    mbn_pkg::t_coord        r_min [3];
    mbn_pkg::t_scale        r_scale_len;
    mbn_pkg::t_scale        r_cached;
    logic                   r_scale_ready;
    logic [CW-1:0]          r_pos [3];
    logic signed [EW-1:0]   r_ext [3];
    logic signed [EW-1:0]   r_sum [3];
    logic [CW-1:0]          r_off [3];
    logic signed [EW-1:0]   r_t [3];
    logic                   r_neg [3];
    logic [EW-1:0]          r_mag [3];
    logic [PW-1:0]          r_prod [3];
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [CW-1:0]          r_norm [3];
    logic [CW-1:0]          r_out_off [3];
    mbn_pkg::t_scale        r_out_scale;

    logic signed [EW-1:0]   ext_01;
    logic signed [EW-1:0]   ext_best;
    logic                   ext_pos;
    logic signed [EW:0]     neg_sum [3];
    logic [EW-1:0]          half [3];
    logic [CW-1:0]          n_off [3];
    logic [RW-1:0]          res [3];
    logic                   ovf_pos [3];
    logic                   ovf_neg [3];
    logic [CW-1:0]          n_norm [3];
    logic                   out_free;

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign out_free  = !r_out_valid || o_out.ready;

    // Largest extent over the three axes; only a positive one is divided.
    assign ext_01   = (r_ext[1] > r_ext[0]) ? r_ext[1] : r_ext[0];
    assign ext_best = (r_ext[2] > ext_01) ? r_ext[2] : ext_01;
    assign ext_pos  = !ext_best[EW-1] && (ext_best != '0);

    assign o_div_req.start   = (r_state == S_EMAX) && ext_pos;
    assign o_div_req.length  = r_scale_len;
    assign o_div_req.divisor = ext_best[CW-1:0];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            // Offset is -(max+min)/2 rounded down, clamped to the coordinate range.
            neg_sum[a] = -$signed({r_sum[a][EW-1], r_sum[a]});
            half[a]    = neg_sum[a][EW:1];
            if (half[a][EW-1] == half[a][CW-1]) begin
                n_off[a] = half[a][CW-1:0];
            end else begin
                n_off[a] = half[a][EW-1] ? COORD_MIN : COORD_MAX;
            end

            // Magnitude result truncated toward zero, then saturated by sign.
            res[a]     = r_prod[a][PW-1:FB];
            ovf_pos[a] = |res[a][RW-1:CW-1];
            ovf_neg[a] = (|res[a][RW-1:CW]) || (res[a][CW-1] && (|res[a][CW-2:0]));
            if (r_neg[a]) begin
                n_norm[a] = ovf_neg[a] ? COORD_MIN : -res[a][CW-1:0];
            end else begin
                n_norm[a] = ovf_pos[a] ? COORD_MAX : res[a][CW-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && (i_cmd.op == mbn_pkg::OP_TRANSFORM)) begin
                    n_state = S_EXT;
                end
            end
            S_EXT:  n_state = r_scale_ready ? S_OFF : S_EMAX;
            S_EMAX: n_state = ext_pos ? S_DIV : S_OFF;
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = S_OFF;
                end
            end
            S_OFF:  n_state = S_SUM;
            S_SUM:  n_state = S_MAG;
            S_MAG:  n_state = S_MUL;
            S_MUL:  n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        if ((r_state == S_OUT) && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_scale_ready <= 1'b0;
            r_scale_len   <= mbn_pkg::SCALE_LEN_RESET;
            for (int a = 0; a < 3; a++) begin
                r_max[a] <= mbn_pkg::BOUND_MAX_INIT;
                r_min[a] <= mbn_pkg::BOUND_MIN_INIT;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (o_cmd_pop) begin
                unique case (i_cmd.op)
                    mbn_pkg::OP_RESTART: begin
                        r_scale_ready <= 1'b0;
                        for (int a = 0; a < 3; a++) begin
                            r_max[a] <= mbn_pkg::BOUND_MAX_INIT;
                            r_min[a] <= mbn_pkg::BOUND_MIN_INIT;
                        end
                    end
                    mbn_pkg::OP_INCLUDE: begin
                        r_scale_ready <= 1'b0;
                        for (int a = 0; a < 3; a++) begin
                            if ($signed(i_cmd.pos[a]) > r_max[a]) begin
                                r_max[a] <= i_cmd.pos[a];
                            end
                            if ($signed(i_cmd.pos[a]) < r_min[a]) begin
                                r_min[a] <= i_cmd.pos[a];
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_EMAX) && !ext_pos) begin
                r_scale_ready <= 1'b1;
            end
            if ((r_state == S_DIV) && i_div_rsp.done) begin
                r_scale_ready <= 1'b1;
            end
            if (i_cfg_we) begin
                r_scale_len   <= i_cfg_wdata;
                r_scale_ready <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.op == mbn_pkg::OP_TRANSFORM)) begin
            for (int a = 0; a < 3; a++) begin
                r_pos[a] <= i_cmd.pos[a];
            end
        end
        if ((r_state == S_EMAX) && !ext_pos) begin
            r_cached <= '1;
        end
        if ((r_state == S_DIV) && i_div_rsp.done) begin
            r_cached <= i_div_rsp.quotient;
        end
        for (int a = 0; a < 3; a++) begin
            if (r_state == S_EXT) begin
                r_ext[a] <= $signed({r_max[a][CW-1], r_max[a]})
                          - $signed({r_min[a][CW-1], r_min[a]});
                r_sum[a] <= $signed({r_max[a][CW-1], r_max[a]})
                          + $signed({r_min[a][CW-1], r_min[a]});
            end
            if (r_state == S_OFF) begin
                r_off[a] <= n_off[a];
            end
            if (r_state == S_SUM) begin
                r_t[a] <= $signed({r_pos[a][CW-1], r_pos[a]})
                        + $signed({r_off[a][CW-1], r_off[a]});
            end
            if (r_state == S_MAG) begin
                r_neg[a] <= r_t[a][EW-1];
                r_mag[a] <= r_t[a][EW-1] ? -r_t[a] : r_t[a];
            end
            if (r_state == S_MUL) begin
                // A magnitude of exactly 2^CW has no low bits set.
                r_prod[a] <= r_mag[a][CW] ? {r_cached, {CW{1'b0}}}
                           : ({{CW{1'b0}}, r_mag[a][CW-1:0]} * {{CW{1'b0}}, r_cached});
            end
            if ((r_state == S_OUT) && out_free) begin
                r_norm[a]    <= n_norm[a];
                r_out_off[a] <= r_off[a];
            end
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out_scale <= r_cached;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.norm_x    = r_norm[0];
    assign o_out.norm_y    = r_norm[1];
    assign o_out.norm_z    = r_norm[2];
    assign o_out.scale_out = r_out_scale;
    assign o_out.offset_x  = r_out_off[0];
    assign o_out.offset_y  = r_out_off[1];
    assign o_out.offset_z  = r_out_off[2];

`ifndef SYNTHESIS
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> (r_state == S_EMAX) && !r_scale_ready)
        else $error("divider started outside the extent step or with a cached scale");

    a_scale_before_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OFF) |-> r_scale_ready || $past(i_cfg_we))
        else $error("offset step entered without a valid cached scale");

    a_zero_extent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMAX) && !ext_pos && !i_cfg_we) |=> (r_cached == '1) && r_scale_ready)
        else $error("non-positive extent did not saturate the scale");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && out_free) |=> o_out.valid && (r_state == S_IDLE))
        else $error("finished transform did not reach the output register");
`endif

endmodule

/* hw/rtl/mesh_bounds_normalizer.sv */
// Channel   Direction  Handshake      Payload
// i_in      in         valid/ready    operation, pos_x, pos_y, pos_z
// o_out     out        valid/ready    norm_x/y/z, scale_out, offset_x/y/z
// i_cfg     in         write enable   scale_length (i_cfg_wdata)
//
// Restart and include beats retire one per cycle while the back end is idle.
// A transform steps the back end through extent, offset, sum, magnitude, multiply
// and output states; recomputing the scale adds a one-bit-a-cycle division.
// Reset is synchronous and active low; it restores the bounds and scale length.
// The front keeps accepting beats into a two-entry queue while a result waits.
module mesh_bounds_normalizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mbn_pkg::COORD_WIDTH-1:0] i_cfg_wdata,
    mbn_in_if.sink                          i_in,
    mbn_out_if.source                       o_out
);

    // Decoded commands travel from the front through a short queue to the
    // back end, so that either side can stall without holding the other.
    logic              front_valid;
    mbn_pkg::t_cmd     front_cmd;
    logic              queue_ready;
    logic              queue_valid;
    mbn_pkg::t_cmd     queue_cmd;
    logic              cmd_pop;

    // The back end starts the divider only for a transform with no cached scale.
    mbn_pkg::t_div_req div_req;
    mbn_pkg::t_div_rsp div_rsp;

    mbn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (queue_ready)
    );

    mbn_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_data  (front_cmd),
        .o_push_ready (queue_ready),
        .o_pop_valid  (queue_valid),
        .o_pop_data   (queue_cmd),
        .i_pop        (cmd_pop)
    );

    mbn_scale_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // The back end owns the bounds, the cached scale and the output register.
    mbn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_out       (o_out)
    );

endmodule

/* bench/mbn_norm_checker.sv */
`timescale 1ns / 100ps

module mbn_norm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mbn_pkg::COORD_WIDTH-1:0] i_cfg_wdata,
    mbn_in_if                               i_in_mon,
    mbn_out_if                              i_out_mon,
    output int                              o_fail_count,
    output int                              o_pending
);
    import mbn_pkg::*;

    localparam longint     C_MAX      = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint     C_MIN      = -C_MAX - 1;
    localparam logic [63:0] FULL_SCALE = (64'd1 << COORD_WIDTH) - 64'd1;
    localparam longint     THOUSAND   = longint'(1000) <<< FRAC_BITS;
    localparam longint     START_SPAN = (THOUSAND > C_MAX) ? C_MAX : THOUSAND;

    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] norm;
        logic [COORD_WIDTH-1:0]      scale;
        logic [2:0][COORD_WIDTH-1:0] offset;
    } t_norm_beat;

    longint      hi_bound [3];
    longint      lo_bound [3];
    logic [63:0] scale_cache;
    bit          scale_valid;
    logic [63:0] target_len;
    t_norm_beat  norm_expected [$];
    int          results_seen = 0;
    int          reported     = 0;

    function automatic longint sat_coord(input longint v);
        if (v > C_MAX) return C_MAX;
        if (v < C_MIN) return C_MIN;
        return v;
    endfunction

    function automatic void restart_bounds();
        for (int a = 0; a < 3; a++) begin
            hi_bound[a] = -START_SPAN;
            lo_bound[a] = START_SPAN;
        end
        scale_valid = 1'b0;
    endfunction

    // Restoring division, one fraction bit at a time, saturating on overflow.
    function automatic logic [63:0] fit_scale();
        longint      span;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        span = hi_bound[0] - lo_bound[0];
        for (int a = 1; a < 3; a++) begin
            if (hi_bound[a] - lo_bound[a] > span) span = hi_bound[a] - lo_bound[a];
        end
        if (span <= 0) return FULL_SCALE;
        d = 64'(span);
        q = target_len / d;
        r = target_len % d;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (q > (FULL_SCALE >> 1)) return FULL_SCALE;
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return (q > FULL_SCALE) ? FULL_SCALE : q;
    endfunction

    // Sign and magnitude multiply, magnitude truncated, then saturated.
    function automatic longint scale_axis(input longint t, input logic [63:0] s);
        bit           neg;
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [127:0] lim;
        neg  = (t < 0);
        mag  = neg ? 64'(-t) : 64'(t);
        prod = ({64'd0, mag} * {64'd0, s}) >> FRAC_BITS;
        lim  = neg ? 128'(C_MAX) + 128'd1 : 128'(C_MAX);
        if (prod > lim) return neg ? C_MIN : C_MAX;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    always @(posedge i_clk) begin : track
        longint     pos [3];
        longint     shift;
        longint     moved;
        t_norm_beat want;
        t_norm_beat seen;
        if (!i_rst_n) begin
            restart_bounds();
            scale_cache = '0;
            target_len  = 64'd1 << FRAC_BITS;
            norm_expected.delete();
        end else begin
            if (i_cfg_we) begin
                target_len  = 64'(i_cfg_wdata);
                scale_valid = 1'b0;
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                pos[0] = longint'(i_in_mon.pos_x);
                pos[1] = longint'(i_in_mon.pos_y);
                pos[2] = longint'(i_in_mon.pos_z);
                case (i_in_mon.operation)
                    OP_RESTART: restart_bounds();
                    OP_INCLUDE: begin
                        for (int a = 0; a < 3; a++) begin
                            if (pos[a] > hi_bound[a]) hi_bound[a] = pos[a];
                            if (pos[a] < lo_bound[a]) lo_bound[a] = pos[a];
                        end
                        scale_valid = 1'b0;
                    end
                    OP_TRANSFORM: begin
                        if (!scale_valid) begin
                            scale_cache = fit_scale();
                            scale_valid = 1'b1;
                        end
                        for (int a = 0; a < 3; a++) begin
                            shift = sat_coord((-(hi_bound[a] + lo_bound[a])) >>> 1);
                            moved = scale_axis(pos[a] + shift, scale_cache);
                            want.offset[a] = shift[COORD_WIDTH-1:0];
                            want.norm[a]   = moved[COORD_WIDTH-1:0];
                        end
                        want.scale = scale_cache[COORD_WIDTH-1:0];
                        norm_expected.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                seen.norm[0]   = i_out_mon.norm_x;
                seen.norm[1]   = i_out_mon.norm_y;
                seen.norm[2]   = i_out_mon.norm_z;
                seen.scale     = i_out_mon.scale_out;
                seen.offset[0] = i_out_mon.offset_x;
                seen.offset[1] = i_out_mon.offset_y;
                seen.offset[2] = i_out_mon.offset_z;
                if (norm_expected.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (reported < 10) begin
                        reported = reported + 1;
                        $display("result beat %0d arrived with nothing expected: norm %h %h %h",
                                 results_seen, seen.norm[0], seen.norm[1], seen.norm[2]);
                    end
                end else begin
                    want = norm_expected.pop_front();
                    if (seen.norm[0] !== want.norm[0] || seen.norm[1] !== want.norm[1] ||
                        seen.norm[2] !== want.norm[2] || seen.scale !== want.scale ||
                        seen.offset[0] !== want.offset[0] ||
                        seen.offset[1] !== want.offset[1] ||
                        seen.offset[2] !== want.offset[2]) begin
                        o_fail_count = o_fail_count + 1;
                        if (reported < 10) begin
                            reported = reported + 1;
                            $display("result beat %0d expected norm %h %h %h scale %h off %h %h %h",
                                     results_seen, want.norm[0], want.norm[1], want.norm[2],
                                     want.scale, want.offset[0], want.offset[1],
                                     want.offset[2]);
                            $display("result beat %0d actual   norm %h %h %h scale %h off %h %h %h",
                                     results_seen, seen.norm[0], seen.norm[1], seen.norm[2],
                                     seen.scale, seen.offset[0], seen.offset[1],
                                     seen.offset[2]);
                        end
                    end
                end
                results_seen = results_seen + 1;
            end
        end
        o_pending = norm_expected.size();
    end

endmodule

/* bench/tb_mesh_bounds_normalizer.sv */
`timescale 1ns / 100ps

module tb_mesh_bounds_normalizer;
    import mbn_pkg::*;

    // A run is abandoned when this many cycles pass with no beat accepted on
    // either channel. The longest honest quiet stretch is the receiver's long
    // hold-off plus a scale division, well under this figure.
    localparam int STALL_LIMIT   = 3000;
    // Cycles allowed for restart and include beats, which produce no result,
    // to drain out of the block before the register is touched or the run ends.
    localparam int SETTLE_CYCLES = 100;
    // Length of the receiver's deliberate hold-off, so that the input queue fills.
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 9;
    localparam int PHASE_BEATS   = 190;

    localparam t_coord EDGE_HI = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam t_coord EDGE_LO = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
    localparam t_coord UNIT_Q  = t_coord'(longint'(1) <<< FRAC_BITS);

    // How widely the coordinates of a vertex are spread.
    typedef enum int {
        SPREAD_UNIT,
        SPREAD_WIDE,
        SPREAD_FULL,
        SPREAD_EDGE,
        SPREAD_BOUND
    } t_spread;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [COORD_WIDTH-1:0] i_cfg_wdata;
    int                     norm_failures;
    int                     results_outstanding;
    int                     quiet_cycles;
    bit                     send_burst;

    mbn_in_if  in_ch ();
    mbn_out_if out_ch ();

    mesh_bounds_normalizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // The checker sits beside the block, watching both channels and the
    // register port; it keeps its own model and counts every disagreement.
    mbn_norm_checker u_norm_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (norm_failures),
        .o_pending    (results_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Draws one coordinate. Vertices of one set usually share a spread, so
    // that extents and scales land in every region from tiny to saturated.
    function automatic t_coord pick_coord(input t_spread spread);
        longint near;
        case (spread)
            SPREAD_UNIT: return t_coord'(int'($urandom_range(0, 524288)) - 262144);
            SPREAD_WIDE: return t_coord'(int'($urandom_range(0, 33554432)) - 16777216);
            SPREAD_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return EDGE_HI;
                    1:       return EDGE_LO;
                    2:       return '0;
                    3:       return t_coord'(1);
                    default: return t_coord'(-1);
                endcase
            end
            SPREAD_BOUND: begin
                // Around plus or minus 1000, where the starting bounds sit.
                near = (longint'(1000) <<< FRAC_BITS) + longint'($urandom_range(0, 131072))
                       - 65536;
                return ($urandom_range(0, 1) == 1) ? t_coord'(near) : t_coord'(-near);
            end
            default: return t_coord'($urandom());
        endcase
    endfunction

    function automatic t_scale pick_length(input int phase);
        case (phase)
            0: return '0;
            1: return '1;
            2: return t_scale'(1);
            3: return t_scale'(longint'(1) <<< FRAC_BITS);
            default: begin
                if ($urandom_range(0, 1) == 1) return t_scale'($urandom());
                return t_scale'($urandom_range(1, 1 << (FRAC_BITS + 4)));
            end
        endcase
    endfunction

    // Offers one beat after a random gap and returns at the edge where it is taken.
    task automatic send_beat(input logic [1:0] op, input t_coord x, input t_coord y,
                             input t_coord z);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.pos_x     <= x;
        in_ch.pos_y     <= y;
        in_ch.pos_z     <= z;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    // Stops offering, waits for every expected result, then lets the block
    // finish any restart or include beats still in flight.
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (results_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input t_scale value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed vertex sets: an optional restart, every vertex
    // included once, then every vertex transformed. Now and then a set skips
    // its restart so bounds accumulate, a transform carries a stray vertex,
    // or a short burst of random operations breaks the pattern.
    task automatic run_mesh_phase(input int budget);
        t_coord      vx [24];
        t_coord      vy [24];
        t_coord      vz [24];
        t_spread     set_spread;
        t_spread     one_spread;
        logic [1:0]  op;
        int          sent;
        int          count;
        int          kind;
        sent = 0;
        while (sent < budget) begin
            send_burst = ($urandom_range(0, 3) == 0);
            kind       = $urandom_range(0, 9);
            if (kind < 8) begin
                count = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24)
                                                    : $urandom_range(1, 5);
                set_spread = t_spread'($urandom_range(SPREAD_UNIT, SPREAD_BOUND));
                for (int i = 0; i < count; i++) begin
                    one_spread = ($urandom_range(0, 4) == 0)
                                 ? t_spread'($urandom_range(SPREAD_UNIT, SPREAD_BOUND))
                                 : set_spread;
                    vx[i] = pick_coord(one_spread);
                    vy[i] = pick_coord(one_spread);
                    vz[i] = pick_coord(one_spread);
                end
                if (kind != 0) begin
                    send_beat(OP_RESTART, pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL),
                              pick_coord(SPREAD_FULL));
                    sent++;
                end
                for (int i = 0; i < count; i++) send_beat(OP_INCLUDE, vx[i], vy[i], vz[i]);
                for (int i = 0; i < count; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_beat(OP_TRANSFORM, pick_coord(SPREAD_FULL),
                                  pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL));
                    end else begin
                        send_beat(OP_TRANSFORM, vx[i], vy[i], vz[i]);
                    end
                end
                sent += 2 * count;
            end else begin
                count = $urandom_range(1, 6);
                for (int i = 0; i < count; i++) begin
                    op = 2'($urandom_range(OP_RESTART, OP_UNUSED));
                    one_spread = t_spread'($urandom_range(SPREAD_UNIT, SPREAD_BOUND));
                    send_beat(op, pick_coord(one_spread), pick_coord(one_spread),
                              pick_coord(one_spread));
                    if (op != OP_UNUSED) sent++;
                end
            end
        end
    endtask

    // Result side. Each result waits a random number of cycles, with bursts
    // of back-to-back acceptance. Twice in the run the receiver holds off
    // for a long stretch so that the block's queue fills and it stalls its input.
    initial begin : result_sink
        int gap;
        int taken;
        bit burst;
        out_ch.ready = 1'b0;
        taken = 0;
        burst = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            if (taken == 150 || taken == 450) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = burst ? 0 : $urandom_range(0, 10);
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            taken++;
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_RESTART;
        in_ch.pos_x     = '0;
        in_ch.pos_y     = '0;
        in_ch.pos_z     = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_rst_n         = 1'b0;
        send_burst      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the reset scale length. A transform straight
        // after reset sees the inverted starting bounds, so the extent is
        // negative and the scale saturates; the corners then saturate the output.
        send_beat(OP_TRANSFORM, '0, '0, '0);
        send_beat(OP_TRANSFORM, EDGE_HI, EDGE_LO, t_coord'(1));
        // The unused selector must leave no trace.
        send_beat(OP_UNUSED, EDGE_HI, EDGE_LO, t_coord'(-1));
        // A single vertex gives a zero extent.
        send_beat(OP_INCLUDE, '0, '0, '0);
        send_beat(OP_TRANSFORM, '0, '0, '0);
        // An extent of one least significant bit overflows the scale.
        send_beat(OP_RESTART, EDGE_LO, EDGE_HI, '0);
        send_beat(OP_INCLUDE, t_coord'(1), '0, '0);
        send_beat(OP_INCLUDE, '0, '0, '0);
        send_beat(OP_TRANSFORM, t_coord'(1), '0, '0);
        send_beat(OP_TRANSFORM, t_coord'(-1), UNIT_Q, -UNIT_Q);
        // The full coordinate range as the extent: a tiny scale.
        send_beat(OP_RESTART, '0, '0, '0);
        send_beat(OP_INCLUDE, EDGE_HI, EDGE_HI, EDGE_HI);
        send_beat(OP_INCLUDE, EDGE_LO, EDGE_LO, EDGE_LO);
        send_beat(OP_TRANSFORM, EDGE_HI, EDGE_HI, EDGE_HI);
        send_beat(OP_TRANSFORM, EDGE_LO, EDGE_LO, EDGE_LO);
        send_beat(OP_TRANSFORM, '0, UNIT_Q, EDGE_LO);
        // A minimum pinned at the most negative value gives the largest
        // offset the bounds can produce, which still sits inside the range.
        send_beat(OP_RESTART, EDGE_HI, EDGE_HI, EDGE_HI);
        send_beat(OP_INCLUDE, EDGE_LO, EDGE_LO, EDGE_LO);
        send_beat(OP_TRANSFORM, EDGE_LO, EDGE_HI, '0);

        // Random phases, each under a fresh scale length written while the
        // block is idle. The first beat after each write transforms against
        // the old bounds, which checks that the write dropped the cached scale.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_quiet();
            write_length(pick_length(phase));
            send_beat(OP_TRANSFORM, pick_coord(SPREAD_WIDE), pick_coord(SPREAD_WIDE),
                      pick_coord(SPREAD_WIDE));
            run_mesh_phase(PHASE_BEATS);
        end

        wait_quiet();
        if (norm_failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
